### sv/rsharp_pkg.sv
package rsharp_pkg;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int CFG_W         = 12;
    localparam int POS_W         = 11;
    localparam int CH_W          = 8;
    localparam int PX_W          = 3 * CH_W;

    typedef logic [CFG_W-1:0] t_size;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [CH_W-1:0]  t_chan;
    typedef logic [PX_W-1:0]  t_px;

    localparam t_size CFG_SIZE_RESET = t_size'(64);

    // centre weights: corner, edge and interior neighbourhoods
    localparam logic [3:0] K_CORNER = 4'd5;
    localparam logic [3:0] K_EDGE   = 4'd7;
    localparam logic [3:0] K_INNER  = 4'd10;

    localparam logic [11:0] CHAN_MAX = 12'd255;

    // which pending result of the current job is being produced
    typedef enum logic [1:0] {
        KIND_UP_LEFT  = 2'b00,
        KIND_UP_LAST  = 2'b01,
        KIND_CUR_LEFT = 2'b10,
        KIND_CUR_LAST = 2'b11
    } t_kind;

endpackage

### sv/rgb_sharpen_3x3_edge_aware_top.sv
// 3x3 edge-aware laplacian sharpen over a square rgb image in raster order.
// input channel: i_in_valid / o_in_ready, one pixel word per handshake
// (i_red_in, i_green_in, i_blue_in). output channel: o_out_valid /
// i_out_ready, one sharpened pixel per word, tagged with o_out_row and
// o_out_col; o_run_last marks the last word caused by an input pixel.
// i_cfg_we / i_cfg_data set the image size (2..MAX_WIDTH, clamped) and
// restart the frame at pixel (0,0); write it only while the block is idle.
// the word for pixel (r-1,c-1) is made once pixel (r,c) has gone from the
// input register into the window and pending job, and is then registered.
// throughput: one pixel per clock while the receiver takes words. the single
// shared sharpen unit makes one word per cycle, so from the second row on the
// last pixel of a row makes two words, pixels of the last row after its first
// make two words and the final pixel of the frame makes four.
// line buffer: two banks of MAX_WIDTH words, one read and one write each
// per cycle, read data registered; entries are not cleared.
// reset clears the position counters, the window and all valid flags and
// sets the size to 64; the block takes pixels in the cycle after reset.
// when the receiver stalls the output word holds, the pending job holds,
// and o_in_ready drops once the input register is also full.
module rgb_sharpen_3x3_edge_aware_top
    import rsharp_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_size       i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_chan       i_red_in,
    input  t_chan       i_green_in,
    input  t_chan       i_blue_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_pos        o_out_row,
    output t_pos        o_out_col,
    output t_chan       o_red_out,
    output t_chan       o_green_out,
    output t_chan       o_blue_out,
    output logic        o_run_last
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

    typedef logic [CW-1:0] t_cnt;

    // configuration and position of the next input pixel
    t_size r_size;
    t_cnt  r_row, r_col;
    t_cnt  n_row, n_col;

    logic [LW-1:0] w_size_ext, w_size;
    t_cnt          w_last;

    // line buffer banks, selected by row parity
    t_px r_bank0 [MAX_WIDTH];
    t_px r_bank1 [MAX_WIDTH];
    t_px r_rd0, r_rd1;

    // input register
    logic r_s1_valid;
    t_px  r_s1_px;
    t_cnt r_s1_row, r_s1_col;

    // window and pending job
    t_px        r_win [3][3];
    logic [3:0] r_b_mask;
    t_cnt       r_b_row, r_b_col;
    logic       r_b_top, r_b_lft;
    logic [3:0] n_b_mask;

    // output register
    logic  r_out_valid;
    t_pos  r_out_row, r_out_col;
    t_px   r_out_px;
    logic  r_out_last;

    logic  w_accept, w_emit, w_b_free, w_s1_to_b, w_single;
    logic  w_is_last_row, w_is_last_col;
    t_kind w_kind;
    logic [2:0] w_rinc, w_cinc;
    logic [1:0] w_cr, w_cc;
    logic [3:0] w_k;
    t_px   w_res;
    t_pos  w_res_row, w_res_col;
    t_px   w_above2, w_above1;

    function automatic t_chan sharpen_chan(input logic [11:0] prod,
                                           input logic [11:0] sum);
        logic [11:0] diff;
        begin
            diff = prod - sum;
            if (sum > prod) begin
                sharpen_chan = '0;
            end else if (diff > CHAN_MAX) begin
                sharpen_chan = CHAN_MAX[CH_W-1:0];
            end else begin
                sharpen_chan = diff[CH_W-1:0];
            end
        end
    endfunction

    // effective size clamped to 2..MAX_WIDTH
    always_comb begin
        w_size_ext = LW'(r_size);
        if (w_size_ext < LW'(2)) begin
            w_size = LW'(2);
        end else if (w_size_ext > LW'(MAX_WIDTH)) begin
            w_size = LW'(MAX_WIDTH);
        end else begin
            w_size = w_size_ext;
        end
        w_last = CW'(w_size - LW'(1));
    end

    // handshake and job flow
    assign w_single   = ((r_b_mask & (r_b_mask - 4'd1)) == 4'd0);
    assign w_emit     = (r_b_mask != 4'd0) && (!r_out_valid || i_out_ready);
    assign w_b_free   = (r_b_mask == 4'd0) || (w_emit && w_single);
    assign w_s1_to_b  = r_s1_valid && w_b_free;
    assign o_in_ready = !r_s1_valid || w_b_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        if (r_col >= w_last) begin
            n_col = '0;
            n_row = (r_row >= w_last) ? '0 : r_row + t_cnt'(1);
        end else begin
            n_col = r_col + t_cnt'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= CFG_SIZE_RESET;
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
            r_row  <= '0;
            r_col  <= '0;
        end else if (w_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // read before write: the bank of this row's parity still holds two rows up
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd0 <= r_bank0[r_col];
            r_rd1 <= r_bank1[r_col];
            if (r_row[0]) begin
                r_bank1[r_col] <= {i_red_in, i_green_in, i_blue_in};
            end else begin
                r_bank0[r_col] <= {i_red_in, i_green_in, i_blue_in};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_to_b) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_px  <= {i_red_in, i_green_in, i_blue_in};
            r_s1_row <= r_row;
            r_s1_col <= r_col;
        end
    end

    assign w_above2      = r_s1_row[0] ? r_rd1 : r_rd0;
    assign w_above1      = r_s1_row[0] ? r_rd0 : r_rd1;
    assign w_is_last_row = (r_s1_row == w_last);
    assign w_is_last_col = (r_s1_col == w_last);

    always_comb begin
        n_b_mask = 4'd0;
        if (r_s1_row != '0) begin
            n_b_mask[0] = (r_s1_col != '0);
            n_b_mask[1] = w_is_last_col;
            n_b_mask[2] = w_is_last_row && (r_s1_col != '0);
            n_b_mask[3] = w_is_last_row && w_is_last_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_mask <= 4'd0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (w_s1_to_b) begin
            r_b_mask <= n_b_mask;
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= w_above2;
            r_win[1][2] <= w_above1;
            r_win[2][2] <= r_s1_px;
        end else if (w_emit) begin
            r_b_mask <= r_b_mask & (r_b_mask - 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_to_b) begin
            r_b_row <= r_s1_row;
            r_b_col <= r_s1_col;
            r_b_top <= (r_s1_row > t_cnt'(1));
            r_b_lft <= (r_s1_col > t_cnt'(1));
        end
    end

    // shared sharpen unit: lowest pending result first
    always_comb begin
        if (r_b_mask[0]) begin
            w_kind = KIND_UP_LEFT;
        end else if (r_b_mask[1]) begin
            w_kind = KIND_UP_LAST;
        end else if (r_b_mask[2]) begin
            w_kind = KIND_CUR_LEFT;
        end else begin
            w_kind = KIND_CUR_LAST;
        end
    end

    always_comb begin
        unique case (w_kind)
            KIND_UP_LEFT: begin
                w_rinc = {2'b11, r_b_top};
                w_cinc = {2'b11, r_b_lft};
            end
            KIND_UP_LAST: begin
                w_rinc = {2'b11, r_b_top};
                w_cinc = 3'b110;
            end
            KIND_CUR_LEFT: begin
                w_rinc = 3'b110;
                w_cinc = {2'b11, r_b_lft};
            end
            default: begin
                w_rinc = 3'b110;
                w_cinc = 3'b110;
            end
        endcase
        w_cr = 2'd1 + {1'b0, w_kind[1]};
        w_cc = 2'd1 + {1'b0, w_kind[0]};
        if (w_rinc[0] && w_cinc[0]) begin
            w_k = K_INNER;
        end else if (w_rinc[0] || w_cinc[0]) begin
            w_k = K_EDGE;
        end else begin
            w_k = K_CORNER;
        end
        w_res_row = t_pos'(w_kind[1] ? r_b_row : r_b_row - t_cnt'(1));
        w_res_col = t_pos'(w_kind[0] ? r_b_col : r_b_col - t_cnt'(1));
    end

    always_comb begin
        logic [11:0] sum;
        logic [11:0] prod;
        t_px         centre;
        centre = r_win[w_cr][w_cc];
        for (int ch = 0; ch < 3; ch++) begin
            sum = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (w_rinc[i] && w_cinc[j]) begin
                        sum = sum + 12'(r_win[i][j][ch*CH_W +: CH_W]);
                    end
                end
            end
            prod = 12'(w_k) * 12'(centre[ch*CH_W +: CH_W]);
            w_res[ch*CH_W +: CH_W] = sharpen_chan(prod, sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_row  <= w_res_row;
            r_out_col  <= w_res_col;
            r_out_px   <= w_res;
            r_out_last <= w_single;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_red_out   = r_out_px[2*CH_W +: CH_W];
    assign o_green_out = r_out_px[CH_W +: CH_W];
    assign o_blue_out  = r_out_px[0 +: CH_W];
    assign o_run_last  = r_out_last;

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= w_last) && (r_col <= w_last))
        else $error("position counter beyond image size");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_b_mask) > 1 && r_s1_valid) |-> !o_in_ready)
        else $error("input taken while a multi-word job is pending");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_run_last) |=> o_out_valid)
        else $error("run ended without its last word");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_mask != 4'd0 && !o_out_valid) |=> o_out_valid)
        else $error("pending result not moved to output register");

endmodule
